FILE: hw/rtl/jnvp_pkg.sv
`default_nettype none

package jnvp_pkg;

    // Reply codes sent back to the host
    localparam logic [7:0] REPLY_DONE     = 8'h00;
    localparam logic [7:0] REPLY_MISMATCH = 8'h03;

    // Result kinds
    localparam logic KIND_PULSE = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // Most results one host byte can produce
    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = 2;

    // Host byte plus TDO samples for its two pulses
    typedef struct packed {
        logic [7:0] rx_byte;
        logic [1:0] tdo_sample;
    } item_t;

    // One pulse or reply
    typedef struct packed {
        logic       result_kind;
        logic       tdi_level;
        logic       tms_level;
        logic [7:0] reply_code;
        logic       last;
    } result_t;

    // Sequencer state
    typedef struct packed {
        logic       in_batch;
        logic [7:0] nibbles_left;
        logic       halted;
    } seq_state_t;

    function automatic result_t make_pulse(input logic [3:0] nib);
        result_t r;
        r.result_kind = KIND_PULSE;
        r.tdi_level   = nib[2];
        r.tms_level   = nib[3];
        r.reply_code  = REPLY_DONE;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic result_t make_reply(input logic [7:0] code);
        result_t r;
        r.result_kind = KIND_REPLY;
        r.tdi_level   = 1'b0;
        r.tms_level   = 1'b0;
        r.reply_code  = code;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/jtag_nibble_vector_player_unit.sv
`default_nettype none
// The first result of a host byte passes the item register and then the result
// register, which loads once it is empty or its last result is being taken.
// Throughput: one byte per cycle for count bytes while no results wait; otherwise
// one byte per result it makes, while result_ready holds high, set by the single
// result output register. A byte is accepted while earlier results still drain.
// Reset (rst_n, async, active low) clears the batch state, halt flag and all valids.

module jtag_nibble_vector_player_unit
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       item_valid,
    output logic                      item_ready,
    input  wire  jnvp_pkg::item_t     item,
    output logic                      result_valid,
    input  wire                       result_ready,
    output jnvp_pkg::result_t         result
);
    import jnvp_pkg::*;

    logic                          item_valid_reg;
    item_t                         item_reg;
    seq_state_t                    state_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    result_t [MAX_RESULTS-1:0]     res_reg;
    result_t [MAX_RESULTS-1:0]     res_next;

    seq_state_t                    step_state;
    result_t [MAX_RESULTS-1:0]     step_results;
    logic [CNT_W-1:0]              step_count;

    logic                          take;
    logic                          drain_free;
    logic                          advance;

    jnvp_step u_step
    (
        .item       (item_reg),
        .state      (state_reg),
        .state_next (step_state),
        .results    (step_results),
        .count      (step_count)
    );

    // Handshake
    assign take         = result_valid && result_ready;
    assign drain_free   = (cnt_reg == CNT_W'(0)) || (cnt_reg == CNT_W'(1) && take);
    assign advance      = item_valid_reg && drain_free;
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = (cnt_reg != CNT_W'(0));
    assign result       = res_reg[0];

    // Result register: load a fresh list or shift out one result
    always_comb
    begin
        cnt_next = cnt_reg;
        res_next = res_reg;
        if (advance)
        begin
            cnt_next = step_count;
            res_next = step_results;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                res_next[i] = res_reg[i+1];
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            state_reg      <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                state_reg <= step_state;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
        res_reg <= res_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/jnvp_step.sv
`default_nettype none

// Decodes one host byte against the sequencer state: produces up to three
// results in order and the state that follows.
module jnvp_step
(
    input  wire  jnvp_pkg::item_t                          item,
    input  wire  jnvp_pkg::seq_state_t                     state,
    output jnvp_pkg::seq_state_t                           state_next,
    output jnvp_pkg::result_t [jnvp_pkg::MAX_RESULTS-1:0]  results,
    output logic [jnvp_pkg::CNT_W-1:0]                     count
);
    import jnvp_pkg::*;

    logic [3:0] nib_lo;
    logic [3:0] nib_hi;
    logic       fail_lo;
    logic       fail_hi;
    logic [7:0] left_one;
    logic [7:0] left_two;
    result_t    res0;
    result_t    res1;
    result_t    res2;

    assign nib_lo   = item.rx_byte[3:0];
    assign nib_hi   = item.rx_byte[7:4];
    assign fail_lo  = nib_lo[1] && (item.tdo_sample[0] != nib_lo[0]);
    assign fail_hi  = nib_hi[1] && (item.tdo_sample[1] != nib_hi[0]);
    assign left_one = state.nibbles_left - 8'd1;
    assign left_two = state.nibbles_left - 8'd2;

    // Result list and next state
    always_comb
    begin
        state_next = state;
        res0       = make_pulse(nib_lo);
        res1       = make_reply(REPLY_DONE);
        res2       = make_reply(REPLY_DONE);
        count      = CNT_W'(0);

        if (state.halted)
        begin
            count = CNT_W'(0);
        end
        else if (!state.in_batch || state.nibbles_left == 8'd0)
        begin
            // Count byte: opens a batch, zero keeps waiting
            state_next.in_batch     = (item.rx_byte != 8'd0);
            state_next.nibbles_left = (item.rx_byte != 8'd0) ? item.rx_byte
                                                             : state.nibbles_left;
        end
        else if (fail_lo)
        begin
            res1              = make_reply(REPLY_MISMATCH);
            count             = CNT_W'(2);
            state_next.halted = 1'b1;
        end
        else if (left_one == 8'd0)
        begin
            // Odd tail: only the low nibble plays
            res1                    = make_reply(REPLY_DONE);
            count                   = CNT_W'(2);
            state_next.in_batch     = 1'b0;
            state_next.nibbles_left = left_one;
        end
        else
        begin
            res1 = make_pulse(nib_hi);
            if (fail_hi)
            begin
                res2                    = make_reply(REPLY_MISMATCH);
                count                   = CNT_W'(3);
                state_next.halted       = 1'b1;
                state_next.nibbles_left = left_one;
            end
            else if (left_two == 8'd0)
            begin
                res2                    = make_reply(REPLY_DONE);
                count                   = CNT_W'(3);
                state_next.in_batch     = 1'b0;
                state_next.nibbles_left = left_two;
            end
            else
            begin
                count                   = CNT_W'(2);
                state_next.nibbles_left = left_two;
            end
        end

        // Mark the final result of this byte
        res0.last = (count == CNT_W'(1));
        res1.last = (count == CNT_W'(2));
        res2.last = (count == CNT_W'(3));
        results   = {res2, res1, res0};
    end

endmodule

`default_nettype wire
